FILE: hw/rtl/oktt_pkg.sv
// Shared types and constants for the ordered keyed table with expiry.
package oktt_pkg;

   localparam int KEY_BITS = 64;
   localparam int AGE_BITS = 32;
   localparam int CNT_BITS = 5;
   localparam int REG_BITS = 31;
   localparam int LIMIT_BITS = 5;
   localparam int STATUS_BITS = 2;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_TAKE_KEY = 3'd1;
   localparam logic [2:0] OP_GET_KEY = 3'd2;
   localparam logic [2:0] OP_CONTAINS = 3'd3;
   localparam logic [2:0] OP_PEEK = 3'd4;
   localparam logic [2:0] OP_TAKE_FIRST = 3'd5;
   localparam logic [2:0] OP_CLEAR = 3'd6;
   localparam logic [2:0] OP_TICK = 3'd7;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   localparam logic [1:0] CSR_LIMIT = 2'd0;
   localparam logic [1:0] CSR_TTL = 2'd1;
   localparam logic [1:0] CSR_INTERVAL = 2'd2;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;
   localparam logic [REG_BITS-1:0] TTL_RESET = 31'd60000;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic load;       // write the item into the tail cell, the first free slot
      logic age;        // advance ages
      logic shift;      // cells at or beyond a remove mark take their right neighbor
      logic sweep;      // remove expired cells, one per cycle, leftmost first
   } cell_cmd_type;

endpackage

FILE: hw/rtl/ordered_keyed_table_with_ttl_core.sv
// Top level of the ordered keyed table with expiry: controller and cell row.
//
// Usage: one operation is a beat on the req_ channel (operation, key, payload);
// each yields exactly one beat on the rsp_ channel. Configuration registers are
// written on the csr_ channel (0 entry limit, 1 TTL, 2 sweep interval), which is
// always ready; write it only while the block is idle.
// Entries live in a row of CAPACITY cells. Each cell compares its key with the
// request in parallel; the first match is chosen by a priority pick.
// An accepted item is registered with its operation, evaluated in the execute
// state, and its result is registered in the response register. Removal
// shifts all cells right of the removed slot by one in the same cycle.
// A tick that sweeps removes expired entries one per cycle, leftmost first,
// and answers only after a further sweep step has found that none is left.
// One item is in work at a time; req_stall is high while busy or while the
// response register holds an untaken beat that the next item would replace.
// Reset empties the table, zeroes the sweep counter and restores register
// defaults. While rsp_stall is high the response beat holds steady.
module ordered_keyed_table_with_ttl_core #(
   parameter int CAPACITY = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_operation,
   input  logic [oktt_pkg::KEY_BITS-1:0]       req_key_high,
   input  logic [oktt_pkg::KEY_BITS-1:0]       req_key_low,
   input  logic [31:0]                         req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [oktt_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic                                rsp_found,
   output logic [31:0]                         rsp_found_payload,
   output logic [oktt_pkg::CNT_BITS-1:0]       rsp_entry_count,
   output logic [oktt_pkg::CNT_BITS-1:0]       rsp_expired_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [31:0]                         csr_data
);
   import oktt_pkg::*;

   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int N_BITS = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [N_BITS-1:0] count_ff, count_in;
   logic [REG_BITS-1:0] countdown_ff, countdown_in;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic [REG_BITS-1:0] ttl_ff, interval_ff;
   logic [2:0] op_ff;
   logic [KEY_BITS-1:0] kh_ff, kl_ff;
   logic [PAYLOAD_BITS-1:0] pl_ff;
   logic [CNT_BITS-1:0] exp_ff, exp_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic found_ff, found_in;
   logic [31:0] fpay_ff, fpay_in;
   logic [CNT_BITS-1:0] ecount_ff, ecount_in;
   logic [CNT_BITS-1:0] xcount_ff, xcount_in;

   cell_cmd_type cmd;
   logic [KEY_BITS-1:0] c_kh [CAPACITY];
   logic [KEY_BITS-1:0] c_kl [CAPACITY];
   logic [PAYLOAD_BITS-1:0] c_pl [CAPACITY];
   logic [AGE_BITS-1:0] c_age [CAPACITY];
   logic [CAPACITY-1:0] live, match_v, exp_v, hit_v, rm_v, rm_left_v, tail_v;

   logic accept;
   logic any_hit;
   logic [IDX_BITS-1:0] hit_idx;
   logic [N_BITS-1:0] limit_eff;
   logic [REG_BITS-1:0] cd_next;
   logic do_sweep;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign csr_ready = 1'b1;

   // Cell row.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_BITS-1:0] nkh, nkl;
      logic [PAYLOAD_BITS-1:0] npl;
      logic [AGE_BITS-1:0] nage;
      if (g == CAPACITY - 1) begin : g_end
         assign nkh = c_kh[g];
         assign nkl = c_kl[g];
         assign npl = c_pl[g];
         assign nage = c_age[g];
      end else begin : g_mid
         assign nkh = c_kh[g+1];
         assign nkl = c_kl[g+1];
         assign npl = c_pl[g+1];
         assign nage = c_age[g+1];
      end
      assign live[g] = N_BITS'(g) < count_ff;
      assign tail_v[g] = N_BITS'(g) == count_ff;
      if (g == 0) begin : g_first
         assign rm_left_v[g] = 1'b0;
      end else begin : g_rest
         assign rm_left_v[g] = rm_left_v[g-1] | rm_v[g-1];
      end
      oktt_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
         .clock(clock), .cmd(cmd), .is_tail(tail_v[g]),
         .remove_here(rm_v[g]), .remove_left(rm_left_v[g]),
         .key_high_in(kh_ff), .key_low_in(kl_ff), .payload_in(pl_ff),
         .nb_key_high(nkh), .nb_key_low(nkl), .nb_payload(npl), .nb_age(nage),
         .ttl(ttl_ff),
         .key_high_ff(c_kh[g]), .key_low_ff(c_kl[g]), .payload_ff(c_pl[g]),
         .age_ff(c_age[g]), .match(match_v[g]), .expired(exp_v[g])
      );
   end

   // First-hit one-hot: by key for key ops, by expiry while sweeping.
   always_comb begin
      logic [CAPACITY-1:0] cand;
      logic seen;
      cand = (state_ff == S_SWEEP) ? (exp_v & live) : (match_v & live);
      seen = 1'b0;
      hit_v = '0;
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cand[i] && !seen) begin
            hit_v[i] = 1'b1;
            hit_idx = IDX_BITS'(i);
            seen = 1'b1;
         end
      end
      any_hit = seen;
   end

   assign limit_eff = (int'(limit_ff) > CAPACITY) ? N_BITS'(CAPACITY)
                                                  : N_BITS'(limit_ff);
   assign cd_next = countdown_ff + REG_BITS'(1);
   assign do_sweep = (interval_ff != '0) && (cd_next >= interval_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      countdown_in = countdown_ff;
      exp_in = exp_ff;
      cmd = '0;
      rm_v = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in = status_ff;
      found_in = found_ff;
      fpay_in = fpay_ff;
      ecount_in = ecount_ff;
      xcount_in = xcount_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            found_in = 1'b0;
            fpay_in = '0;
            xcount_in = '0;
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            case (op_ff) inside
               OP_ADD: begin
                  if (count_ff >= limit_eff) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     cmd.load = 1'b1;
                     count_in = count_ff + N_BITS'(1);
                  end
               end
               OP_TAKE_KEY, OP_GET_KEY, OP_CONTAINS: begin
                  if (!any_hit) begin
                     status_in = ST_MISS;
                  end else begin
                     found_in = 1'b1;
                     fpay_in = 32'(c_pl[hit_idx]);
                     if (op_ff == OP_TAKE_KEY) begin
                        cmd.shift = 1'b1;
                        rm_v = hit_v;
                        count_in = count_ff - N_BITS'(1);
                     end
                  end
               end
               OP_PEEK, OP_TAKE_FIRST: begin
                  if (count_ff == '0) begin
                     status_in = ST_MISS;
                  end else begin
                     found_in = 1'b1;
                     fpay_in = 32'(c_pl[0]);
                     if (op_ff == OP_TAKE_FIRST) begin
                        cmd.shift = 1'b1;
                        rm_v[0] = 1'b1;
                        count_in = count_ff - N_BITS'(1);
                     end
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  cmd.age = 1'b1;
                  if (interval_ff != '0) begin
                     countdown_in = do_sweep ? '0 : cd_next;
                     if (do_sweep) begin
                        state_in = S_SWEEP;
                        rsp_valid_in = 1'b0;
                        exp_in = '0;
                     end
                  end
               end
            endcase
            ecount_in = CNT_BITS'(count_in);
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (any_hit) begin
               cmd.shift = 1'b1;
               rm_v = hit_v;
               count_in = count_ff - N_BITS'(1);
               exp_in = exp_ff + CNT_BITS'(1);
            end else begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in = ST_OK;
               found_in = 1'b0;
               fpay_in = '0;
               xcount_in = exp_ff;
               ecount_in = CNT_BITS'(count_ff);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         countdown_ff <= '0;
         limit_ff <= LIMIT_RESET;
         ttl_ff <= TTL_RESET;
         interval_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         countdown_ff <= countdown_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LIMIT: limit_ff <= csr_data[LIMIT_BITS-1:0];
               CSR_TTL: ttl_ff <= csr_data[REG_BITS-1:0];
               CSR_INTERVAL: begin
                  interval_ff <= csr_data[REG_BITS-1:0];
                  countdown_ff <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
      status_ff <= status_in;
      found_ff <= found_in;
      fpay_ff <= fpay_in;
      ecount_ff <= ecount_in;
      xcount_ff <= xcount_in;
      if (accept) begin
         op_ff <= req_operation;
         kh_ff <= req_key_high;
         kl_ff <= req_key_low;
         pl_ff <= PAYLOAD_BITS'(req_payload);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found = found_ff;
   assign rsp_found_payload = fpay_ff;
   assign rsp_entry_count = ecount_ff;
   assign rsp_expired_count = xcount_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= N_BITS'(CAPACITY))
      else $error("entry count beyond capacity");
   a_one_remove: assert property (@(posedge clock) disable iff (reset)
      $onehot0(rm_v))
      else $error("more than one slot removed in a cycle");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !accept)
      else $error("item accepted while busy");
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff != OP_TICK) |=> rsp_valid_ff)
      else $error("missing response");
   a_sweep_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP && any_hit) |=> count_ff == $past(count_ff) - N_BITS'(1))
      else $error("sweep did not remove an entry");
`endif

endmodule

FILE: hw/rtl/oktt_cell.sv
// One table slot: holds an entry and takes its right neighbor when compacting.
module oktt_cell #(
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                              clock,
   input  oktt_pkg::cell_cmd_type            cmd,
   input  logic                              is_tail,
   input  logic                              remove_here,
   input  logic                              remove_left,
   input  logic [oktt_pkg::KEY_BITS-1:0]     key_high_in,
   input  logic [oktt_pkg::KEY_BITS-1:0]     key_low_in,
   input  logic [PAYLOAD_BITS-1:0]           payload_in,
   input  logic [oktt_pkg::KEY_BITS-1:0]     nb_key_high,
   input  logic [oktt_pkg::KEY_BITS-1:0]     nb_key_low,
   input  logic [PAYLOAD_BITS-1:0]           nb_payload,
   input  logic [oktt_pkg::AGE_BITS-1:0]     nb_age,
   input  logic [oktt_pkg::REG_BITS-1:0]     ttl,
   output logic [oktt_pkg::KEY_BITS-1:0]     key_high_ff,
   output logic [oktt_pkg::KEY_BITS-1:0]     key_low_ff,
   output logic [PAYLOAD_BITS-1:0]           payload_ff,
   output logic [oktt_pkg::AGE_BITS-1:0]     age_ff,
   output logic                              match,
   output logic                              expired
);
   import oktt_pkg::*;

   assign match = (key_high_ff == key_high_in) && (key_low_ff == key_low_in);
   assign expired = age_ff >= {1'b0, ttl};

   // remove_left means a cell to the left is removed, remove_here that this one is: take the neighbor.
   always_ff @(posedge clock) begin
      if (cmd.load && is_tail) begin
         key_high_ff <= key_high_in;
         key_low_ff <= key_low_in;
         payload_ff <= payload_in;
         age_ff <= '0;
      end else if (cmd.shift && (remove_here || remove_left)) begin
         key_high_ff <= nb_key_high;
         key_low_ff <= nb_key_low;
         payload_ff <= nb_payload;
         age_ff <= nb_age;
      end else if (cmd.age && (age_ff != {AGE_BITS{1'b1}})) begin
         age_ff <= age_ff + AGE_BITS'(1);
      end
   end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the ordered keyed table with expiry.
`timescale 1ns / 1ps

module testbench;
   import oktt_pkg::*;

   localparam int DEPTH = 16;
   localparam int RANDOM_ITEMS = 1400;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [31:0] found_payload;
      logic [4:0]  entry_count;
      logic [4:0]  expired_count;
   } table_answer_type;

   typedef struct {
      logic [2:0]  op;
      logic [63:0] kh;
      logic [63:0] kl;
      logic [31:0] pl;
      logic        typed;
      table_answer_type answer;
   } table_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_operation;
   logic [63:0] req_key_high;
   logic [63:0] req_key_low;
   logic [31:0] req_payload;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_status;
   logic rsp_found;
   logic [31:0] rsp_found_payload;
   logic [4:0] rsp_entry_count;
   logic [4:0] rsp_expired_count;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   ordered_keyed_table_with_ttl_core uut (.*);

   // Shadow copy of the table.
   logic [63:0] shadow_kh [DEPTH];
   logic [63:0] shadow_kl [DEPTH];
   logic [31:0] shadow_pl [DEPTH];
   logic [31:0] shadow_age [DEPTH];
   int unsigned shadow_count;
   logic [30:0] shadow_countdown;
   logic [4:0] shadow_limit;
   logic [30:0] shadow_ttl;
   logic [30:0] shadow_interval;

   table_answer_type pending_answers[$];
   int unsigned error_total;
   int unsigned answers_seen;
   int unsigned cycle_count;
   logic long_hold;
   int unsigned sweeps_seen;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic void shadow_remove(int unsigned pos);
      for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
         shadow_kh[i] = shadow_kh[i + 1];
         shadow_kl[i] = shadow_kl[i + 1];
         shadow_pl[i] = shadow_pl[i + 1];
         shadow_age[i] = shadow_age[i + 1];
      end
      shadow_count--;
   endfunction

   function automatic table_answer_type table_predict(logic [2:0] op, logic [63:0] kh,
                                                       logic [63:0] kl, logic [31:0] pl);
      table_answer_type a;
      int unsigned limit;
      int pos;
      int unsigned i;
      a = '0;
      limit = (shadow_limit > DEPTH) ? DEPTH : shadow_limit;
      pos = -1;
      case (op) inside
         OP_ADD: begin
            if (shadow_count >= limit) begin
               a.status = ST_OVERFLOW;
            end else begin
               shadow_kh[shadow_count] = kh;
               shadow_kl[shadow_count] = kl;
               shadow_pl[shadow_count] = pl;
               shadow_age[shadow_count] = 0;
               shadow_count++;
            end
         end
         OP_TAKE_KEY, OP_GET_KEY, OP_CONTAINS: begin
            for (i = 0; i < shadow_count; i++)
               if (pos < 0 && shadow_kh[i] == kh && shadow_kl[i] == kl) pos = i;
            if (pos < 0) begin
               a.status = ST_MISS;
            end else begin
               a.found = 1'b1;
               a.found_payload = shadow_pl[pos];
               if (op == OP_TAKE_KEY) shadow_remove(pos);
            end
         end
         OP_PEEK, OP_TAKE_FIRST: begin
            if (shadow_count == 0) begin
               a.status = ST_MISS;
            end else begin
               a.found = 1'b1;
               a.found_payload = shadow_pl[0];
               if (op == OP_TAKE_FIRST) shadow_remove(0);
            end
         end
         OP_CLEAR: shadow_count = 0;
         default: begin
            for (i = 0; i < shadow_count; i++)
               if (shadow_age[i] != 32'hFFFF_FFFF) shadow_age[i]++;
            if (shadow_interval != 0) begin
               shadow_countdown = shadow_countdown + 1;
               if (shadow_countdown >= shadow_interval) begin
                  shadow_countdown = 0;
                  i = 0;
                  while (i < shadow_count) begin
                     if (shadow_age[i] >= {1'b0, shadow_ttl}) begin
                        shadow_remove(i);
                        a.expired_count++;
                     end else begin
                        i++;
                     end
                  end
                  if (a.expired_count != 0) sweeps_seen++;
               end
            end
         end
      endcase
      a.entry_count = 5'(shadow_count);
      return a;
   endfunction

   // Response side: random stall, plus one long hold-off.
   initial begin
      int unsigned wait_cycles;
      rsp_stall = 1'b1;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
            long_hold = 1'b0;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock iff (rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      table_answer_type exp_a;
      if (!reset && rsp_valid && !rsp_stall) begin
         answers_seen <= answers_seen + 1;
         if (pending_answers.size() == 0) begin
            $error("unexpected beat on the response channel");
            error_total++;
         end else begin
            exp_a = pending_answers.pop_front();
            if (rsp_status !== exp_a.status) begin
               $error("status: expected %0d, got %0d", exp_a.status, rsp_status);
               error_total++;
            end
            if (rsp_found !== exp_a.found) begin
               $error("found: expected %0d, got %0d", exp_a.found, rsp_found);
               error_total++;
            end
            if (rsp_found_payload !== exp_a.found_payload) begin
               $error("found_payload: expected %h, got %h", exp_a.found_payload,
                      rsp_found_payload);
               error_total++;
            end
            if (rsp_entry_count !== exp_a.entry_count) begin
               $error("entry_count: expected %0d, got %0d", exp_a.entry_count,
                      rsp_entry_count);
               error_total++;
            end
            if (rsp_expired_count !== exp_a.expired_count) begin
               $error("expired_count: expected %0d, got %0d", exp_a.expired_count,
                      rsp_expired_count);
               error_total++;
            end
         end
      end
   end

   task automatic send_item(logic [2:0] op, logic [63:0] kh, logic [63:0] kl,
                            logic [31:0] pl, logic typed, table_answer_type typed_a);
      int unsigned gap;
      table_answer_type a;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key_high <= kh;
      req_key_low <= kl;
      req_payload <= pl;
      @(posedge clock iff !req_stall);
      a = table_predict(op, kh, kl, pl);
      if (typed && a !== typed_a) begin
         $error("directed row: predictor disagrees with typed answer");
         error_total++;
      end
      pending_answers.push_back(a);
   endtask

   task automatic drain_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_answers.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock iff csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LIMIT: shadow_limit = value[4:0];
         CSR_TTL: shadow_ttl = value[30:0];
         default: begin
            shadow_interval = value[30:0];
            shadow_countdown = 0;
         end
      endcase
   endtask

   function automatic table_answer_type ans(logic [1:0] s, logic f, logic [31:0] p,
                                             logic [4:0] c, logic [4:0] e);
      table_answer_type a;
      a.status = s;
      a.found = f;
      a.found_payload = p;
      a.entry_count = c;
      a.expired_count = e;
      return a;
   endfunction

   initial begin
      table_row_type rows[$];
      table_row_type r;
      logic [63:0] key_pool_h [8];
      logic [63:0] key_pool_l [8];
      int unsigned k;
      logic [2:0] op;
      int unsigned phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_ADD;
      req_key_high = '0;
      req_key_low = '0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = CSR_LIMIT;
      csr_data = '0;
      cycle_count = 0;
      error_total = 0;
      answers_seen = 0;
      long_hold = 1'b0;
      sweeps_seen = 0;
      shadow_count = 0;
      shadow_countdown = 0;
      shadow_limit = LIMIT_RESET;
      shadow_ttl = TTL_RESET;
      shadow_interval = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty misses, extremes, duplicates, and every operation.
      rows = '{
         '{OP_PEEK, 64'h0, 64'h0, 32'h0, 1'b1, ans(ST_MISS, 0, 0, 0, 0)},
         '{OP_TAKE_FIRST, 64'h0, 64'h0, 32'h0, 1'b1, ans(ST_MISS, 0, 0, 0, 0)},
         '{OP_GET_KEY, '1, '1, 32'h0, 1'b1, ans(ST_MISS, 0, 0, 0, 0)},
         '{OP_TICK, 64'h0, 64'h0, 32'h0, 1'b1, ans(ST_OK, 0, 0, 0, 0)},
         '{OP_ADD, '1, '1, '1, 1'b1, ans(ST_OK, 0, 0, 1, 0)},
         '{OP_ADD, 64'h0, 64'h0, 32'h0, 1'b1, ans(ST_OK, 0, 0, 2, 0)},
         '{OP_ADD, '1, '1, 32'h1234_5678, 1'b1, ans(ST_OK, 0, 0, 3, 0)},
         '{OP_CONTAINS, '1, '1, 32'h0, 1'b1, ans(ST_OK, 1, '1, 3, 0)},
         '{OP_GET_KEY, 64'h0, 64'h0, 32'h0, 1'b1, ans(ST_OK, 1, 0, 3, 0)},
         '{OP_TAKE_KEY, '1, '1, 32'h0, 1'b1, ans(ST_OK, 1, '1, 2, 0)},
         '{OP_GET_KEY, '1, '1, 32'h0, 1'b0, ans(0, 0, 0, 0, 0)},
         '{OP_PEEK, 64'h0, 64'h0, 32'h0, 1'b0, ans(0, 0, 0, 0, 0)},
         '{OP_TICK, 64'h0, 64'h0, 32'h0, 1'b0, ans(0, 0, 0, 0, 0)},
         '{OP_TAKE_FIRST, 64'h0, 64'h0, 32'h0, 1'b0, ans(0, 0, 0, 0, 0)},
         '{OP_CLEAR, 64'h0, 64'h0, 32'h0, 1'b1, ans(ST_OK, 0, 0, 0, 0)}
      };
      foreach (rows[i]) begin
         r = rows[i];
         send_item(r.op, r.kh, r.kl, r.pl, r.typed, r.answer);
      end
      // Fill to capacity and overflow.
      for (int i = 0; i < 17; i++)
         send_item(OP_ADD, 64'(i), 64'(~i), 32'(i), 1'b1,
                   ans(i < 16 ? ST_OK : ST_OVERFLOW, 0, 0,
                       i < 16 ? 5'(i + 1) : 5'd16, 0));
      drain_idle();

      // Limit below the count, then sweep with zero-ish TTL.
      write_register(CSR_LIMIT, 32'd3);
      write_register(CSR_TTL, 32'd1);
      write_register(CSR_INTERVAL, 32'd1);
      send_item(OP_ADD, '0, '0, '0, 1'b1, ans(ST_OVERFLOW, 0, 0, 16, 0));
      send_item(OP_TICK, '0, '0, '0, 1'b1, ans(ST_OK, 0, 0, 0, 16));
      drain_idle();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_LIMIT, 32'd16);
               write_register(CSR_TTL, 32'd60000);
               write_register(CSR_INTERVAL, 32'd0);
            end
            1: begin
               write_register(CSR_LIMIT, 32'd31);
               write_register(CSR_TTL, 32'd3);
               write_register(CSR_INTERVAL, 32'd2);
            end
            2: begin
               write_register(CSR_LIMIT, 32'd0);
               write_register(CSR_TTL, 32'h7FFF_FFFF);
               write_register(CSR_INTERVAL, 32'h7FFF_FFFF);
            end
            3: begin
               write_register(CSR_LIMIT, 32'd8);
               write_register(CSR_TTL, 32'd5);
               write_register(CSR_INTERVAL, 32'd1);
            end
            4: begin
               write_register(CSR_LIMIT, 32'd12);
               write_register(CSR_TTL, 32'd10);
               write_register(CSR_INTERVAL, 32'd3);
            end
            default: begin
               write_register(CSR_LIMIT, 32'hFFFF_FFE1);
               write_register(CSR_TTL, 32'hFFFF_FFFF);
               write_register(CSR_INTERVAL, 32'd4);
            end
         endcase
         for (int i = 0; i < 8; i++) begin
            key_pool_h[i] = {$urandom, $urandom};
            key_pool_l[i] = {$urandom, $urandom};
         end
         if (phase == 1) long_hold = 1'b1;
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
            k = $urandom_range(0, 7);
            case ($urandom_range(0, 9)) inside
               [0:2]: op = OP_ADD;
               3: op = OP_TAKE_KEY;
               4: op = OP_GET_KEY;
               5: op = OP_CONTAINS;
               6: op = ($urandom_range(0, 1) == 0) ? OP_PEEK : OP_TAKE_FIRST;
               7: op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_TICK;
               default: op = OP_TICK;
            endcase
            if ($urandom_range(0, 9) == 0)
               send_item(op, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                         1'b0, '0);
            else
               send_item(op, key_pool_h[k], key_pool_l[k], $urandom, 1'b0, '0);
         end
         drain_idle();
      end

      $display("Run covered %0d responses over six register settings, %0d sweeps removed entries.",
               answers_seen, sweeps_seen);
      if (error_total == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/oktt_pkg.sv
hw/rtl/oktt_cell.sv
hw/rtl/ordered_keyed_table_with_ttl_core.sv
sim/testbench.sv
